// ----- rtl/lfp_pkg.sv -----
// ----------------------------------------------------------------------------
// lfp_pkg
// Types and constants shared by the line follower controller and its adder.
// ----------------------------------------------------------------------------
package lfp_pkg;

    localparam int SENSOR_COUNT = 7;
    localparam int IDX_W        = 3;
    localparam int ALU_W        = 16;
    localparam int DUTY_W       = 12;
    localparam int FRAME_W      = 14;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 12;
    localparam int LOST_W       = 8;

    localparam logic [DUTY_W-1:0] DUTY_MAX        = 12'd4095;
    localparam logic [LOST_W-1:0] LOST_MAX        = 8'd255;
    localparam logic [DUTY_W-1:0] BASE_SPEED_RST  = 12'd1500;
    localparam logic [DUTY_W-1:0] GAIN_RST        = 12'd90;
    localparam logic [LOST_W-1:0] LOST_LIMIT_RST  = 8'd40;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_LIMIT = 2'd2;

    typedef struct packed {
        logic                      start_switch;
        logic [SENSOR_COUNT-1:0]   sensor_bits;
    } in_word_t;

    typedef struct packed {
        logic [FRAME_W-1:0] right_word;
        logic [FRAME_W-1:0] left_word;
        logic [1:0]         led_word;
    } out_word_t;

    typedef struct packed {
        logic signed [ALU_W-1:0] a;
        logic signed [ALU_W-1:0] b;
        logic                    sub;
    } alu_req_t;

    function automatic logic signed [3:0] pos_weight(input logic [IDX_W-1:0] idx);
        logic signed [3:0] w;
        unique case (idx)
            3'd0:    w = -4'sd3;
            3'd1:    w = -4'sd2;
            3'd2:    w = -4'sd1;
            3'd3:    w =  4'sd0;
            3'd4:    w =  4'sd1;
            3'd5:    w =  4'sd2;
            3'd6:    w =  4'sd3;
            default: w =  4'sd0;
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/lfp_alu.sv -----
// ----------------------------------------------------------------------------
// lfp_alu
// Shared 16-bit signed adder/subtractor driven by the controller sequencer.
// ----------------------------------------------------------------------------
module lfp_alu
    import lfp_pkg::*;
(
    input  alu_req_t                req,
    output logic signed [ALU_W-1:0] result
);

    logic [ALU_W-1:0] b_op;

    assign b_op   = req.sub ? ~req.b : req.b;
    assign result = $signed(req.a + b_op + ALU_W'(req.sub));

endmodule

// ----- rtl/line_follow_p_controller.sv -----
// ----------------------------------------------------------------------------
// line_follow_p_controller
// Proportional line follower: turns a 7-bit sensor word and the start switch
// into two motor frames and an LED word. One 16-bit adder does the position,
// division, gain and duty arithmetic under a small sequencer. The sensor bits
// are scanned one per cycle, then the mean is found by repeated subtraction
// and the bias by repeated addition of the gain, then both duties are formed.
// Switch-off and line-lost items skip the scan and go straight to output. A
// result waits to be written while the output register is full and unread.
// The next word is accepted while a finished result waits in the output
// register.
// ----------------------------------------------------------------------------
module line_follow_p_controller
    import lfp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_ABS, ST_DIV, ST_MUL, ST_RIGHT, ST_LEFT, ST_EMIT
    } state_t;

    state_t                  state_reg;
    logic [DUTY_W-1:0]       base_speed_reg;
    logic [DUTY_W-1:0]       gain_reg;
    logic [LOST_W-1:0]       lost_limit_reg;
    logic [LOST_W-1:0]       lost_count_reg;
    logic [LOST_W-1:0]       lost_count_next;
    logic [SENSOR_COUNT-1:0] sensor_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W-1:0]        cnt_reg;
    logic [IDX_W-1:0]        q_reg;
    logic                    neg_reg;
    logic signed [ALU_W-1:0] acc_reg;
    logic signed [ALU_W-1:0] bias_reg;
    logic [DUTY_W-1:0]       right_duty_reg;
    logic [1:0]              led_reg;
    out_word_t               out_reg;
    logic                    m_valid_reg;

    alu_req_t                alu_req;
    logic signed [ALU_W-1:0] alu_res;
    logic                    out_free;
    logic                    accept;
    logic                    lost_now;
    logic                    emit;

    function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [ALU_W-1:0] v);
        logic [DUTY_W-1:0] d;
        if (v < 0) begin
            d = '0;
        end else if (v > $signed({{(ALU_W-DUTY_W){1'b0}}, DUTY_MAX})) begin
            d = DUTY_MAX;
        end else begin
            d = v[DUTY_W-1:0];
        end
        return d;
    endfunction

    lfp_alu u_alu (
        .req    (alu_req),
        .result (alu_res)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = ((state_reg == ST_LEFT) || (state_reg == ST_EMIT)) && out_free;
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;

    always_comb begin
        if (!s_data.start_switch) begin
            lost_count_next = '0;
        end else if (s_data.sensor_bits == '0) begin
            lost_count_next = (lost_count_reg == LOST_MAX) ? lost_count_reg
                                                           : lost_count_reg + 1'b1;
        end else begin
            lost_count_next = '0;
        end
        lost_now = s_data.start_switch && (lost_count_next >= lost_limit_reg);
    end

    always_comb begin
        alu_req = '0;
        unique case (state_reg)
            ST_SCAN: begin
                alu_req.a   = acc_reg;
                alu_req.b   = ALU_W'(pos_weight(idx_reg));
                alu_req.sub = 1'b0;
            end
            ST_ABS: begin
                alu_req.a   = '0;
                alu_req.b   = acc_reg;
                alu_req.sub = 1'b1;
            end
            ST_DIV: begin
                alu_req.a   = acc_reg;
                alu_req.b   = $signed({{(ALU_W-IDX_W){1'b0}}, cnt_reg});
                alu_req.sub = 1'b1;
            end
            ST_MUL: begin
                alu_req.a   = bias_reg;
                alu_req.b   = $signed({{(ALU_W-DUTY_W){1'b0}}, gain_reg});
                alu_req.sub = 1'b0;
            end
            ST_RIGHT: begin
                alu_req.a   = $signed({{(ALU_W-DUTY_W){1'b0}}, base_speed_reg});
                alu_req.b   = bias_reg;
                alu_req.sub = neg_reg;
            end
            ST_LEFT: begin
                alu_req.a   = $signed({{(ALU_W-DUTY_W){1'b0}}, base_speed_reg});
                alu_req.b   = bias_reg;
                alu_req.sub = !neg_reg;
            end
            ST_IDLE, ST_EMIT: begin
                alu_req = '0;
            end
            default: begin
                alu_req = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            base_speed_reg <= BASE_SPEED_RST;
            gain_reg       <= GAIN_RST;
            lost_limit_reg <= LOST_LIMIT_RST;
            lost_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_BASE_SPEED: base_speed_reg <= cfg_wdata[DUTY_W-1:0];
                    CFG_GAIN:       gain_reg       <= cfg_wdata[DUTY_W-1:0];
                    CFG_LOST_LIMIT: lost_limit_reg <= cfg_wdata[LOST_W-1:0];
                    default: ;
                endcase
            end

            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        lost_count_reg <= lost_count_next;
                        sensor_reg     <= s_data.sensor_bits;
                        acc_reg        <= '0;
                        cnt_reg        <= '0;
                        idx_reg        <= '0;
                        if (!s_data.start_switch || lost_now) begin
                            led_reg   <= {lost_now, s_data.start_switch};
                            state_reg <= ST_EMIT;
                        end else begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (sensor_reg[idx_reg]) begin
                        acc_reg <= alu_res;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == IDX_W'(SENSOR_COUNT - 1)) begin
                        state_reg <= ST_ABS;
                    end
                end
                ST_ABS: begin
                    neg_reg  <= acc_reg[ALU_W-1];
                    bias_reg <= '0;
                    q_reg    <= '0;
                    if (acc_reg[ALU_W-1]) begin
                        acc_reg <= alu_res;
                    end
                    state_reg <= (cnt_reg == '0) ? ST_MUL : ST_DIV;
                end
                ST_DIV: begin
                    if (!alu_res[ALU_W-1]) begin
                        acc_reg <= alu_res;
                        q_reg   <= q_reg + 1'b1;
                    end else begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (q_reg == '0) begin
                        state_reg <= ST_RIGHT;
                    end else begin
                        bias_reg <= alu_res;
                        q_reg    <= q_reg - 1'b1;
                    end
                end
                ST_RIGHT: begin
                    right_duty_reg <= clamp_duty(alu_res);
                    state_reg      <= ST_LEFT;
                end
                ST_LEFT: begin
                    if (out_free) begin
                        out_reg.right_word <= {1'b1, 1'b0, right_duty_reg};
                        out_reg.left_word  <= {1'b1, 1'b0, clamp_duty(alu_res)};
                        out_reg.led_word   <= 2'b01;
                        state_reg          <= ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        out_reg.right_word <= '0;
                        out_reg.left_word  <= '0;
                        out_reg.led_word   <= led_reg;
                        state_reg          <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a word is in progress");

    a_stop_words: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.led_word != 2'b01)) |->
            (m_data.right_word == '0 && m_data.left_word == '0))
        else $error("motor words not stopped when off or line lost");

    a_run_words: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.led_word == 2'b01)) |->
            (m_data.right_word[13] && m_data.left_word[13]
             && !m_data.right_word[12] && !m_data.left_word[12]))
        else $error("running motor word lacks go bit");

    a_finish_needs_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.led_word[1]) |-> m_data.led_word[0])
        else $error("finish flag without start switch");

    a_quotient_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> (q_reg <= 3'd3))
        else $error("line position magnitude out of range");

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for line_follow_p_controller. A local predictor tracks
// the no-line counter and the three registers and works out the motor and
// LED words for every sensor word the block takes. A checker compares each
// result word with the oldest prediction. Directed tests cover the sensor
// patterns, line-lost handling, register extremes, a zero limit and counter
// saturation. A random test then runs with changing settings and stall rates.
// ----------------------------------------------------------------------------
module tb_top
    import lfp_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_BASE_SPEED;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_word_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_word_t             m_data;

    int        base_speed_q;
    int        gain_q;
    int        lost_limit_q;
    int        lost_cnt_q;
    out_word_t frames_due[$];
    out_word_t want_word;
    int        err_cnt       = 0;
    int        cycle_cnt     = 0;
    int        send_idle_pct = 0;
    int        rcv_idle_pct  = 0;

    line_follow_p_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles", $time, cycle_cnt);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    function automatic logic [DUTY_W-1:0] clamp_duty(input int v);
        if (v < 0) return '0;
        if (v > 4095) return DUTY_MAX;
        return v[DUTY_W-1:0];
    endfunction

    function automatic out_word_t next_motor_frames(input in_word_t w);
        out_word_t r;
        int        sum;
        int        cnt;
        int        pos;
        int        bias;
        int        k;
        r = '0;
        if (!w.start_switch) begin
            lost_cnt_q = 0;
            return r;
        end
        if (w.sensor_bits == '0) begin
            if (lost_cnt_q < 255) lost_cnt_q++;
        end else begin
            lost_cnt_q = 0;
        end
        if (lost_cnt_q >= lost_limit_q) begin
            r.led_word = 2'b11;
            return r;
        end
        sum = 0;
        cnt = 0;
        for (k = 0; k < SENSOR_COUNT; k++) begin
            if (w.sensor_bits[k]) begin
                sum += k - 3;
                cnt++;
            end
        end
        pos  = (cnt == 0) ? 0 : sum / cnt;
        bias = gain_q * pos;
        r.right_word = {1'b1, 1'b0, clamp_duty(base_speed_q + bias)};
        r.left_word  = {1'b1, 1'b0, clamp_duty(base_speed_q - bias)};
        r.led_word   = 2'b01;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (frames_due.size() == 0) begin
                err_cnt++;
                $display("%0t unexpected word: actual %h", $time, m_data);
            end else begin
                want_word = frames_due.pop_front();
                if (m_data.right_word !== want_word.right_word) begin
                    err_cnt++;
                    $display("%0t right_word: expected %h actual %h", $time,
                             want_word.right_word, m_data.right_word);
                end
                if (m_data.left_word !== want_word.left_word) begin
                    err_cnt++;
                    $display("%0t left_word: expected %h actual %h", $time,
                             want_word.left_word, m_data.left_word);
                end
                if (m_data.led_word !== want_word.led_word) begin
                    err_cnt++;
                    $display("%0t led_word: expected %h actual %h", $time,
                             want_word.led_word, m_data.led_word);
                end
            end
        end
    end

    task automatic send_word(input logic sw, input logic [SENSOR_COUNT-1:0] bits);
        in_word_t w;
        w.start_switch = sw;
        w.sensor_bits  = bits;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        frames_due.push_back(next_motor_frames(w));
    endtask

    task automatic drain_frames();
        s_valid <= 1'b0;
        do @(posedge aclk); while (frames_due.size() != 0);
    endtask

    task automatic set_config(input int base, input int gain, input int limit_word);
        drain_frames();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_BASE_SPEED;
        cfg_wdata <= base[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_index <= CFG_GAIN;
        cfg_wdata <= gain[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_index <= CFG_LOST_LIMIT;
        cfg_wdata <= limit_word[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        base_speed_q = base & 12'hFFF;
        gain_q       = gain & 12'hFFF;
        lost_limit_q = limit_word & 8'hFF;
        @(posedge aclk);
    endtask

    task automatic send_line_word();
        logic [SENSOR_COUNT-1:0] bits;
        if ($urandom_range(2) == 0) begin
            bits = 7'd1 << $urandom_range(SENSOR_COUNT - 1);
        end else begin
            bits = SENSOR_COUNT'($urandom_range(127, 1));
        end
        send_word(1'b1, bits);
    endtask

    task automatic test_sensor_patterns();
        int k;
        send_word(1'b0, 7'h7F);
        send_word(1'b1, 7'h00);
        for (k = 0; k < SENSOR_COUNT; k++) send_word(1'b1, 7'd1 << k);
        send_word(1'b1, 7'h7F);
        send_word(1'b1, 7'h03);
        send_word(1'b1, 7'h60);
        send_word(1'b1, 7'h07);
        send_word(1'b1, 7'h55);
        send_word(1'b1, 7'h2A);
        send_word(1'b1, 7'h0D);
        send_word(1'b1, 7'h58);
        send_word(1'b0, 7'h00);
    endtask

    task automatic test_line_lost();
        set_config(2048, 300, 3);
        send_word(1'b1, 7'h10);
        repeat (5) send_word(1'b1, 7'h00);
        send_word(1'b1, 7'h01);
        repeat (2) send_word(1'b1, 7'h00);
        send_word(1'b0, 7'h00);
        repeat (4) send_word(1'b1, 7'h00);
        drain_frames();
        send_word(1'b1, 7'h40);
    endtask

    task automatic test_config_extremes();
        set_config(4095, 4095, 255);
        send_word(1'b1, 7'h01);
        send_word(1'b1, 7'h40);
        send_word(1'b1, 7'h08);
        set_config(0, 4095, 1);
        send_word(1'b1, 7'h00);
        send_word(1'b1, 7'h20);
        send_word(1'b1, 7'h02);
        set_config(0, 0, 12'hF02);
        send_word(1'b1, 7'h01);
        send_word(1'b1, 7'h00);
        send_word(1'b1, 7'h00);
        send_word(1'b1, 7'h00);
    endtask

    task automatic test_zero_limit();
        set_config(1500, 90, 0);
        send_word(1'b1, 7'h00);
        send_word(1'b1, 7'h7F);
        send_word(1'b1, 7'h04);
        send_word(1'b0, 7'h15);
        send_word(1'b1, 7'h40);
    endtask

    task automatic test_counter_saturation();
        set_config(1000, 50, 255);
        repeat (258) send_word(1'b1, 7'h00);
        send_word(1'b1, 7'h18);
        set_config(1000, 50, 200);
        repeat (260) send_word(1'b1, 7'h00);
        send_word(1'b1, 7'h00);
        send_word(1'b1, 7'h03);
    endtask

    task automatic test_random_traffic();
        int ph;
        int sub;
        int sent;
        int n;
        int sel;
        for (ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 58 : 0;
            rcv_idle_pct  = (ph == 0) ? 58 : (ph == 1) ? 18 : 0;
            for (sub = 0; sub < 2; sub++) begin
                set_config($urandom_range(4095), $urandom_range(4095),
                           ($urandom_range(3) == 0) ? $urandom_range(4095)
                                                    : $urandom_range(12));
                sent = 0;
                while (sent < 80) begin
                    sel = $urandom_range(99);
                    if (sel < 55) begin
                        n = $urandom_range(8, 1);
                        repeat (n) send_line_word();
                    end else if (sel < 80) begin
                        n = $urandom_range(lost_limit_q + 2);
                        if (n > 15) n = $urandom_range(15);
                        repeat (n) send_word(1'b1, 7'h00);
                        send_line_word();
                        n++;
                    end else if (sel < 90) begin
                        send_word(1'b0, SENSOR_COUNT'($urandom_range(127)));
                        n = 1;
                    end else begin
                        send_word(1'($urandom_range(1)),
                                  SENSOR_COUNT'($urandom_range(127)));
                        n = 1;
                    end
                    sent += n;
                end
                if (sub == 0) drain_frames();
            end
        end
    endtask

    initial begin
        send_idle_pct = 18;
        rcv_idle_pct  = 58;
        base_speed_q  = BASE_SPEED_RST;
        gain_q        = GAIN_RST;
        lost_limit_q  = LOST_LIMIT_RST;
        lost_cnt_q    = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_sensor_patterns();
        test_line_lost();
        test_config_extremes();
        test_zero_limit();
        test_counter_saturation();
        test_random_traffic();
        drain_frames();
        repeat (40) @(posedge aclk);
        if (err_cnt == 0 && frames_due.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/lfp_pkg.sv
rtl/lfp_alu.sv
rtl/line_follow_p_controller.sv
bench/tb_top.sv
